// File: src/inpf_pkg.sv
package inpf_pkg;

	localparam int TIME_W = 48;
	localparam int DUR_W  = 31;
	localparam int ID_W   = 24;
	localparam int END_W  = 49;

	typedef logic [END_W-1:0] end_time_t;
	typedef logic [ID_W-1:0]  evt_num_t;

	typedef struct packed {
		logic                start_of_trace;
		logic [TIME_W-1:0]   t_start;
		logic [DUR_W-1:0]    duration;
		evt_num_t            evt_num;
	} evt_item_t;

	typedef struct packed {
		logic      has_parent;
		evt_num_t  encl_id;
		logic      stack_overflow;
	} res_item_t;

	typedef struct packed {
		end_time_t end_time;
		evt_num_t  id;
	} stack_entry_t;

	typedef logic [0:0] alu_op_t;
	localparam alu_op_t ALU_ADD = 1'b0;
	localparam alu_op_t ALU_SUB = 1'b1;

	typedef struct packed {
		alu_op_t   op;
		end_time_t a;
		end_time_t b;
	} alu_req_t;

	typedef struct packed {
		end_time_t sum;
		logic      lt;
	} alu_rsp_t;

endpackage

// File: src/inpf_stream_if.sv
interface inpf_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: src/inpf_alu.sv
module inpf_alu import inpf_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic             is_sub;
	logic [END_W-1:0] b_eff;
	logic [END_W:0]   full;

	// one adder: a + b, or a + ~b + 1 whose carry tells a >= b
	always_comb begin
		is_sub  = (req.op == ALU_SUB);
		b_eff   = is_sub ? ~req.b : req.b;
		full    = {1'b0, req.a} + {1'b0, b_eff} + {{END_W{1'b0}}, is_sub};
		rsp.sum = full[END_W-1:0];
		rsp.lt  = is_sub & ~full[END_W];
	end

endmodule

// File: src/inpf_stack.sv
module inpf_stack import inpf_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  stack_entry_t             wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output stack_entry_t             rd_data
);

	stack_entry_t mem_q [DEPTH];
	stack_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/interval_nesting_parent_finder_top.sv
// interval nesting parent finder
//
// evt channel (sink): one trace event per item, sorted by start time. res channel
// (source): exactly one result per event, in order: has_parent, encl_id and
// stack_overflow. both use valid/ready; an item moves when both are high.
// the open-interval stack lives in a STACK_DEPTH-entry memory with registered read.
// a single 49-bit adder forms the end time and then does every end-time compare.
// per event: read the stack top, then compare its end time with the new end;
// an entry that ends earlier is popped and the next one read, until an
// enclosing entry is found or the stack is empty; then the result is loaded
// and the event is pushed. every event is popped at most once.
// evt.ready is high only while the sequencer is idle; the next event may be
// accepted while the previous result still waits in the output register.
// if res is stalled, the push of the next event waits until its result can be
// loaded. reset clears the sequencer, the stack count and the output valid;
// stack contents are never read above the count, so they need no clearing.
module interval_nesting_parent_finder_top import inpf_pkg::*; #(
	parameter int STACK_DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	inpf_stream_if.sink   evt,
	inpf_stream_if.source res
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_CMP  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	end_time_t     end_q;
	evt_num_t      id_q;
	logic          has_parent_q;
	evt_num_t      parent_q;
	logic          res_valid_q;
	res_item_t     res_data_q;

	alu_req_t      alu_req;
	alu_rsp_t      alu_rsp;
	stack_entry_t  rd_data;
	logic          rd_en;
	logic          wr_en;
	logic [CW-1:0] count_m1;
	logic          evt_fire;
	logic          out_free;
	logic          full;

	evt_item_t     evt_data;
	assign evt_data = evt.data;

	inpf_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	inpf_stack #(.DEPTH(STACK_DEPTH)) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data ({end_q, id_q}),
		.rd_en   (rd_en),
		.rd_addr (count_m1[AW-1:0]),
		.rd_data (rd_data)
	);

	assign count_m1  = count_q - CW'(1);
	assign evt.ready = (state_q == S_IDLE);
	assign evt_fire  = evt.valid & evt.ready;
	assign out_free  = ~res_valid_q | res.ready;
	assign full      = (count_q == CW'(STACK_DEPTH));
	assign rd_en     = (state_q == S_READ) && (count_q != '0);
	assign wr_en     = (state_q == S_DONE) && out_free && !full;

	// adder forms the end time while idle, compares stack top otherwise
	always_comb begin
		if (state_q == S_IDLE) begin
			alu_req.op = ALU_ADD;
			alu_req.a  = {1'b0, evt_data.t_start};
			alu_req.b  = {{(END_W-DUR_W){1'b0}}, evt_data.duration};
		end else begin
			alu_req.op = ALU_SUB;
			alu_req.a  = rd_data.end_time;
			alu_req.b  = end_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			has_parent_q <= 1'b0;
			parent_q     <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (evt_fire) begin
						has_parent_q <= 1'b0;
						parent_q     <= '0;
						if (evt_data.start_of_trace) begin
							count_q <= '0;
						end
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= (count_q == '0) ? S_DONE : S_CMP;
				end
				S_CMP: begin
					if (alu_rsp.lt) begin
						count_q <= count_m1;
						state_q <= S_READ;
					end else begin
						has_parent_q <= 1'b1;
						parent_q     <= rd_data.id;
						state_q      <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						if (!full) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (evt_fire) begin
			end_q <= alu_rsp.sum;
			id_q  <= evt_data.evt_num;
		end
		if (state_q == S_DONE && out_free) begin
			res_data_q.has_parent     <= has_parent_q;
			res_data_q.encl_id        <= parent_q;
			res_data_q.stack_overflow <= full;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

endmodule

// File: src/inpf_checker.sv
module inpf_checker import inpf_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      evt_valid,
	input logic      evt_ready,
	input logic      res_valid,
	input logic      res_ready,
	input res_item_t res_data
);

	// output item holds while stalled
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed or dropped while stalled");

	// no parent means a zero id
	a_no_parent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.has_parent |-> res_data.encl_id == '0)
		else $error("enclosing id nonzero without parent");

	// an accepted event keeps the block busy: ready is low in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready |=> !evt_ready)
		else $error("ready right after accept");

	// a result never shows up the cycle after an accept
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready && !res_valid |=> !res_valid)
		else $error("result too early");

endmodule

bind interval_nesting_parent_finder_top inpf_checker u_inpf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.evt_valid (evt.valid),
	.evt_ready (evt.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
